[rtl/predator_prey_automaton_step_assert.svh]
// Assertion macros for the predator-prey generation block.
// Expect signals named clock and reset in the including module.
`ifndef PREDATOR_PREY_AUTOMATON_STEP_ASSERT_SVH
`define PREDATOR_PREY_AUTOMATON_STEP_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define PPA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a condition in the cycle after its trigger.
`define PPA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/ppa_pkg.sv]
// Shared types and constants of the predator-prey generation block.
// No dependencies; imported by every module of the block but the line buffer.
`default_nettype none

package ppa_pkg;

   localparam logic [1:0] CELL_EMPTY = 2'd0;
   localparam logic [1:0] CELL_PREY  = 2'd1;
   localparam logic [1:0] CELL_PRED  = 2'd2;
   localparam logic [1:0] CELL_BAD   = 2'd3;

   localparam logic [1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_PREY_THR    = 2'd2;
   localparam logic [1:0] CSR_PRED_THR    = 2'd3;

   localparam logic [6:0] GRID_WIDTH_RESET  = 7'd64;
   localparam logic [6:0] GRID_HEIGHT_RESET = 7'd64;
   // 0.85 of 256, rounded to nearest
   localparam logic [8:0] THR_RESET         = 9'd218;

   // window row and column of each neighbor direction
   localparam logic [1:0] DIR_ROW [8] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1, 2'd2};
   localparam logic [1:0] DIR_COL [8] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};

   typedef struct packed {
      logic        mode;
      logic [1:0]  old_cell;
      logic [63:0] prey_random;
      logic [63:0] predator_random;
   } ppa_req_type;

   typedef struct packed {
      logic [1:0] new_cell;
      logic       frame_end;
   } ppa_rsp_type;

   // which neighbors of a window center lie inside the grid
   typedef struct packed {
      logic up;
      logic down;
      logic left;
      logic right;
   } ppa_edge_type;

   typedef struct packed {
      ppa_edge_type n_edge;
      logic         emit;
      logic         last;
   } ppa_tag_type;

   typedef struct packed {
      logic [1:0]  cell_a;
      logic [1:0]  cell_b;
      logic [63:0] prey_random;
      logic [63:0] predator_random;
   } ppa_old_line_type;

   typedef struct packed {
      logic [1:0] cell_a;
      logic [1:0] cell_b;
   } ppa_mid_line_type;

endpackage

`default_nettype wire

[rtl/ppa_line_buf.sv]
// Line buffer memory: one write and one registered read per cycle.
// A read of the address written in the same cycle returns the new data.
`default_nettype none

module ppa_line_buf #(
   parameter int DW = 4,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   output logic      [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/ppa_old_win.sv]
// 3x3 window over the old grid and the spawn rules that give the middle cell.
// Depends on ppa_pkg.
`default_nettype none

module ppa_old_win
   import ppa_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             shift,
   input  wire logic [1:0]       new_cell,
   input  ppa_old_line_type      line,
   input  ppa_edge_type          edge_mask,
   input  wire logic [8:0]       prey_thr,
   input  wire logic [8:0]       pred_thr,
   output logic      [1:0]       mid_cell
);

   logic [1:0]  win_ff [3][3];
   logic [1:0]  win_in [3][3];
   logic [63:0] prey_r_ff, prey_c_ff, pred_r_ff, pred_c_ff;
   logic [63:0] prey_r_in, prey_c_in, pred_r_in, pred_c_in;

   always_comb begin
      win_in    = win_ff;
      prey_r_in = prey_r_ff;
      prey_c_in = prey_c_ff;
      pred_r_in = pred_r_ff;
      pred_c_in = pred_c_ff;
      if (shift) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r][0] = win_ff[r][1];
            win_in[r][1] = win_ff[r][2];
         end
         win_in[0][2] = line.cell_b;
         win_in[1][2] = line.cell_a;
         win_in[2][2] = new_cell;
         prey_c_in    = prey_r_ff;
         prey_r_in    = line.prey_random;
         pred_c_in    = pred_r_ff;
         pred_r_in    = line.predator_random;
      end
   end

   always_ff @(posedge clock) begin
      win_ff    <= win_in;
      prey_r_ff <= prey_r_in;
      prey_c_ff <= prey_c_in;
      pred_r_ff <= pred_r_in;
      pred_c_ff <= pred_c_in;
   end

   always_comb begin
      logic [1:0] nb;
      logic       in_grid;
      logic       prey_hit;
      logic       pred_hit;
      prey_hit = 1'b0;
      pred_hit = 1'b0;
      for (int k = 0; k < 8; k++) begin
         nb      = win_ff[DIR_ROW[k]][DIR_COL[k]];
         in_grid = (DIR_COL[k] != 2'd0 || edge_mask.left)
                && (DIR_COL[k] != 2'd2 || edge_mask.right)
                && (DIR_ROW[k] != 2'd0 || edge_mask.up)
                && (DIR_ROW[k] != 2'd2 || edge_mask.down);
         if (in_grid && nb == CELL_PREY && {1'b0, prey_c_ff[k*8 +: 8]} < prey_thr) begin
            prey_hit = 1'b1;
         end
         if (in_grid && nb == CELL_PRED && {1'b0, pred_c_ff[k*8 +: 8]} < pred_thr) begin
            pred_hit = 1'b1;
         end
      end
      mid_cell = win_ff[1][1];
      if (win_ff[1][1] == CELL_EMPTY && prey_hit) begin
         mid_cell = CELL_PREY;
      end else if (win_ff[1][1] == CELL_PREY && pred_hit) begin
         mid_cell = CELL_PRED;
      end
   end

endmodule

`default_nettype wire

[rtl/ppa_mid_win.sv]
// 3x3 window over the middle grid and the starvation rule for predators.
// Depends on ppa_pkg.
`default_nettype none

module ppa_mid_win
   import ppa_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         shift,
   input  wire logic [1:0]   new_cell,
   input  ppa_mid_line_type  line,
   input  ppa_edge_type      edge_mask,
   output logic      [1:0]   final_cell
);

   logic [1:0] win_ff [3][3];
   logic [1:0] win_in [3][3];

   always_comb begin
      win_in = win_ff;
      if (shift) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r][0] = win_ff[r][1];
            win_in[r][1] = win_ff[r][2];
         end
         win_in[0][2] = line.cell_b;
         win_in[1][2] = line.cell_a;
         win_in[2][2] = new_cell;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   always_comb begin
      logic in_grid;
      logic fed;
      fed = 1'b0;
      for (int k = 0; k < 8; k++) begin
         in_grid = (DIR_COL[k] != 2'd0 || edge_mask.left)
                && (DIR_COL[k] != 2'd2 || edge_mask.right)
                && (DIR_ROW[k] != 2'd0 || edge_mask.up)
                && (DIR_ROW[k] != 2'd2 || edge_mask.down);
         if (in_grid && win_ff[DIR_ROW[k]][DIR_COL[k]] == CELL_PREY) begin
            fed = 1'b1;
         end
      end
      final_cell = win_ff[1][1];
      if (win_ff[1][1] == CELL_PRED && !fed) begin
         final_cell = CELL_EMPTY;
      end
   end

endmodule

`default_nettype wire

[rtl/predator_prey_automaton_step.sv]
// One generation of a stochastic predator-prey automaton on a raster stream.
// Input words carry old cells in raster order with their random draw bytes;
// after the W*H cell words a frame takes 2*W+2 drain words (mode 1, or any
// word once all cells are in). A drain word while cells are still expected
// is taken and dropped. Width and height latch at the first cell of a frame.
// Result words carry new cells in raster order; frame_end marks the last.
// The result for cell n belongs to input word n+2*W+2; once that word is
// taken it enters the old line read stage, then moves through old window,
// middle read, middle window and the output register to rsp. Throughput is
// one word per cycle while rsp_stall does not hold the pipeline, set by the
// single read and write port of each line buffer memory.
// A stalled result holds in the output register while the pipeline keeps
// filling its empty stages; req_stall rises only once every stage is full.
// Reset (synchronous) empties the pipeline, restarts the frame counters and
// loads the register defaults (64 x 64, thresholds 218). Line buffers need
// no clearing: every entry read for an in-grid neighbor is written earlier
// in the same frame. Configuration writes take effect at once for the
// thresholds and with the next frame for the geometry.
// Depends on ppa_pkg, ppa_line_buf, ppa_old_win, ppa_mid_win.
`default_nettype none

`include "predator_prey_automaton_step_assert.svh"

module predator_prey_automaton_step
   import ppa_pkg::*;
#(
   parameter int MAX_WIDTH = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  ppa_req_type      req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output ppa_rsp_type      rsp_data,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [8:0]  csr_wdata
);

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int XW = $clog2(MAX_WIDTH);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int YW = HW + 2;

   localparam logic signed [YW-1:0] Y_ONE     = 1;
   localparam logic signed [YW-1:0] Y_M_START = -2;
   localparam logic signed [YW-1:0] Y_N_WIDE  = -3;
   localparam logic signed [YW-1:0] Y_N_NARROW = -4;

   // configuration registers
   logic [6:0] grid_width_ff, grid_height_ff;
   logic [8:0] prey_thr_ff, pred_thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_WIDTH_RESET;
         grid_height_ff <= GRID_HEIGHT_RESET;
         prey_thr_ff    <= THR_RESET;
         pred_thr_ff    <= THR_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:  grid_width_ff  <= csr_wdata[6:0];
            CSR_GRID_HEIGHT: grid_height_ff <= csr_wdata[6:0];
            CSR_PREY_THR:    prey_thr_ff    <= csr_wdata;
            CSR_PRED_THR:    pred_thr_ff    <= csr_wdata;
            default:         prey_thr_ff    <= prey_thr_ff;
         endcase
      end
   end

   // saturate geometry into 1..MAX
   logic [WW-1:0] gw_clamp;
   logic [HW-1:0] gh_clamp;

   always_comb begin
      if (grid_width_ff == '0) begin
         gw_clamp = WW'(1);
      end else if (32'(grid_width_ff) > 32'(MAX_WIDTH)) begin
         gw_clamp = WW'(MAX_WIDTH);
      end else begin
         gw_clamp = WW'(grid_width_ff);
      end
      if (grid_height_ff == '0) begin
         gh_clamp = HW'(1);
      end else if (32'(grid_height_ff) > 32'(MAX_HEIGHT)) begin
         gh_clamp = HW'(MAX_HEIGHT);
      end else begin
         gh_clamp = HW'(grid_height_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Slot counters: position of the incoming word (p), of the old-window
   // center (m = p-W-1) and of the middle-window center (n = p-2W-2).
   // ---------------------------------------------------------------------
   logic                 frame_active_ff;
   logic [WW-1:0]        act_w_ff;
   logic [HW-1:0]        act_h_ff;
   logic [XW-1:0]        xp_ff, xm_ff, xn_ff;
   logic signed [YW-1:0] yp_ff, ym_ff, yn_ff;

   logic [WW-1:0]        w_cur;
   logic [HW-1:0]        h_cur;
   logic signed [YW-1:0] h_s;
   logic [XW-1:0]        xp_cur, xm_cur, xn_cur;
   logic signed [YW-1:0] yp_cur, ym_cur, yn_cur;
   logic [XW-1:0]        xp_nxt, xm_nxt, xn_nxt;
   logic signed [YW-1:0] yp_nxt, ym_nxt, yn_nxt;

   function automatic logic at_row_end(input logic [XW-1:0] x, input logic [WW-1:0] w);
      return WW'(x) == (w - WW'(1));
   endfunction

   always_comb begin
      if (frame_active_ff) begin
         w_cur  = act_w_ff;
         h_cur  = act_h_ff;
         xp_cur = xp_ff;
         yp_cur = yp_ff;
         xm_cur = xm_ff;
         ym_cur = ym_ff;
         xn_cur = xn_ff;
         yn_cur = yn_ff;
      end else begin
         w_cur  = gw_clamp;
         h_cur  = gh_clamp;
         xp_cur = '0;
         yp_cur = '0;
         xm_cur = XW'(gw_clamp - WW'(1));
         ym_cur = Y_M_START;
         if (gw_clamp >= WW'(2)) begin
            xn_cur = XW'(gw_clamp - WW'(2));
            yn_cur = Y_N_WIDE;
         end else begin
            xn_cur = '0;
            yn_cur = Y_N_NARROW;
         end
      end
      h_s = $signed({2'b00, h_cur});

      xp_nxt = at_row_end(xp_cur, w_cur) ? '0 : xp_cur + XW'(1);
      yp_nxt = at_row_end(xp_cur, w_cur) ? yp_cur + Y_ONE : yp_cur;
      xm_nxt = at_row_end(xm_cur, w_cur) ? '0 : xm_cur + XW'(1);
      ym_nxt = at_row_end(xm_cur, w_cur) ? ym_cur + Y_ONE : ym_cur;
      xn_nxt = at_row_end(xn_cur, w_cur) ? '0 : xn_cur + XW'(1);
      yn_nxt = at_row_end(xn_cur, w_cur) ? yn_cur + Y_ONE : yn_cur;
   end

   // classify the incoming word
   logic         in_cells, drop_word, take, slot;
   logic [1:0]   cell_clean;
   ppa_edge_type m_edge, n_edge;
   logic         slot_emit, slot_last;

   always_comb begin
      in_cells  = yp_cur < h_s;
      drop_word = in_cells && req_data.mode;
      take      = req_valid && !req_stall;
      slot      = take && !drop_word;
      // cell code three counts as empty; drain words carry no cell
      cell_clean = (in_cells && req_data.old_cell != CELL_BAD) ? req_data.old_cell
                                                                : CELL_EMPTY;

      m_edge.left  = xm_cur != '0;
      m_edge.right = !at_row_end(xm_cur, w_cur);
      m_edge.up    = ym_cur > $signed(YW'(0));
      m_edge.down  = ym_cur < (h_s - Y_ONE);

      n_edge.left  = xn_cur != '0;
      n_edge.right = !at_row_end(xn_cur, w_cur);
      n_edge.up    = yn_cur > $signed(YW'(0));
      n_edge.down  = yn_cur < (h_s - Y_ONE);

      slot_emit = !yn_cur[YW-1];
      slot_last = slot_emit && at_row_end(xn_cur, w_cur) && (yn_cur == (h_s - Y_ONE));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_active_ff <= 1'b0;
         act_w_ff        <= '0;
         act_h_ff        <= '0;
         xp_ff           <= '0;
         yp_ff           <= '0;
         xm_ff           <= '0;
         ym_ff           <= '0;
         xn_ff           <= '0;
         yn_ff           <= '0;
      end else if (slot) begin
         if (slot_last) begin
            // frame done: back to slot zero, geometry latches again
            frame_active_ff <= 1'b0;
            xp_ff           <= '0;
            yp_ff           <= '0;
         end else begin
            frame_active_ff <= 1'b1;
            act_w_ff        <= w_cur;
            act_h_ff        <= h_cur;
            xp_ff           <= xp_nxt;
            yp_ff           <= yp_nxt;
            xm_ff           <= xm_nxt;
            ym_ff           <= ym_nxt;
            xn_ff           <= xn_nxt;
            yn_ff           <= yn_nxt;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline: A (old line read) -> B (old window) -> C (middle line read)
   // -> D (middle window) -> output register. Each stage moves on when the
   // next one is empty or moving.
   // ---------------------------------------------------------------------
   logic             a_vld_ff, b_vld_ff, c_vld_ff, d_vld_ff;
   logic [1:0]       a_cell_ff;
   logic [XW-1:0]    a_x_ff, b_x_ff, c_x_ff;
   logic [63:0]      a_prey_ff, a_pred_ff;
   ppa_edge_type     a_medge_ff, b_medge_ff;
   ppa_tag_type      a_tag_ff, b_tag_ff, c_tag_ff, d_tag_ff;
   logic [1:0]       c_mid_ff;
   logic             rsp_valid_ff;
   ppa_rsp_type      rsp_data_ff;

   logic             out_free, d_go, d_free, c_go, c_free, b_go, b_free, a_go, a_free;
   logic [1:0]       mid_cell, final_cell;
   ppa_old_line_type old_rd, old_wr;
   ppa_mid_line_type mid_rd, mid_wr;
   logic [$bits(ppa_old_line_type)-1:0] old_rd_bits;
   logic [$bits(ppa_mid_line_type)-1:0] mid_rd_bits;

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      d_go      = d_vld_ff && (!d_tag_ff.emit || out_free);
      d_free    = !d_vld_ff || d_go;
      c_go      = c_vld_ff && d_free;
      c_free    = !c_vld_ff || c_go;
      b_go      = b_vld_ff && c_free;
      b_free    = !b_vld_ff || b_go;
      a_go      = a_vld_ff && b_free;
      a_free    = !a_vld_ff || a_go;
      req_stall = !a_free;

      old_rd = ppa_old_line_type'(old_rd_bits);
      mid_rd = ppa_mid_line_type'(mid_rd_bits);

      // push the newest cell into the line, age the previous row by one
      old_wr.cell_a          = a_cell_ff;
      old_wr.cell_b          = old_rd.cell_a;
      old_wr.prey_random     = a_prey_ff;
      old_wr.predator_random = a_pred_ff;
      mid_wr.cell_a          = c_mid_ff;
      mid_wr.cell_b          = mid_rd.cell_a;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         c_vld_ff     <= 1'b0;
         d_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (a_free) a_vld_ff <= slot;
         if (b_free) b_vld_ff <= a_vld_ff;
         if (c_free) c_vld_ff <= b_vld_ff;
         if (d_free) d_vld_ff <= c_vld_ff;
         if (d_go && d_tag_ff.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload: load on stage entry, hold otherwise
   always_ff @(posedge clock) begin
      if (slot) begin
         a_cell_ff        <= cell_clean;
         a_x_ff           <= xp_cur;
         a_prey_ff        <= req_data.prey_random;
         a_pred_ff        <= req_data.predator_random;
         a_medge_ff       <= m_edge;
         a_tag_ff.n_edge  <= n_edge;
         a_tag_ff.emit    <= slot_emit;
         a_tag_ff.last    <= slot_last;
      end
      if (a_go) begin
         b_x_ff     <= a_x_ff;
         b_medge_ff <= a_medge_ff;
         b_tag_ff   <= a_tag_ff;
      end
      if (b_go) begin
         c_x_ff   <= b_x_ff;
         c_mid_ff <= mid_cell;
         c_tag_ff <= b_tag_ff;
      end
      if (c_go) begin
         d_tag_ff <= c_tag_ff;
      end
      if (d_go && d_tag_ff.emit) begin
         rsp_data_ff.new_cell  <= final_cell;
         rsp_data_ff.frame_end <= d_tag_ff.last;
      end
   end

   ppa_line_buf #(
      .DW($bits(ppa_old_line_type)),
      .DEPTH(MAX_WIDTH)
   ) u_old_line (
      .clock   (clock),
      .rd_en   (slot),
      .rd_addr (xp_cur),
      .wr_en   (a_go),
      .wr_addr (a_x_ff),
      .wr_data (old_wr),
      .rd_data (old_rd_bits)
   );

   ppa_old_win u_old_win (
      .clock     (clock),
      .shift     (a_go),
      .new_cell  (a_cell_ff),
      .line      (old_rd),
      .edge_mask (b_medge_ff),
      .prey_thr  (prey_thr_ff),
      .pred_thr  (pred_thr_ff),
      .mid_cell  (mid_cell)
   );

   ppa_line_buf #(
      .DW($bits(ppa_mid_line_type)),
      .DEPTH(MAX_WIDTH)
   ) u_mid_line (
      .clock   (clock),
      .rd_en   (b_go),
      .rd_addr (b_x_ff),
      .wr_en   (c_go),
      .wr_addr (c_x_ff),
      .wr_data (mid_wr),
      .rd_data (mid_rd_bits)
   );

   ppa_mid_win u_mid_win (
      .clock      (clock),
      .shift      (c_go),
      .new_cell   (c_mid_ff),
      .line       (mid_rd),
      .edge_mask  (d_tag_ff.n_edge),
      .final_cell (final_cell)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a new result never overwrites one that is still waiting
   `PPA_ASSERT_NOW(a_rsp_no_overwrite, d_go && d_tag_ff.emit, out_free, "result overwritten")
   // the final drain word of a frame sends the counters back to slot zero
   `PPA_ASSERT_NEXT(a_frame_restart, slot && slot_last, !frame_active_ff && xp_ff == '0, "no frame restart")
   // a dropped drain word leaves the slot counter alone
   `PPA_ASSERT_NEXT(a_drop_holds, take && drop_word && frame_active_ff, $stable(xp_ff) && $stable(yp_ff), "dropped word advanced")

endmodule

`default_nettype wire

[tb/ppa_checker.sv]
// Checker for the predator-prey generation block: watches both channels,
// predicts new cells from accepted input words and compares result words.
// Depends on ppa_pkg.
`timescale 1ns / 1ps

module ppa_checker
   import ppa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  ppa_req_type      req_data,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  ppa_rsp_type      rsp_data,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [8:0]  csr_wdata,
   output int               fail_count,
   output int               pending_count
);

   localparam int MAXW = 64;
   localparam int MAXH = 64;
   localparam int LD = 2 * MAXW + 4;
   localparam int RD = MAXW + 2;

   logic [1:0]  old_line [LD];
   logic [1:0]  mid_line [LD];
   logic [63:0] prey_dly [RD];
   logic [63:0] pred_dly [RD];
   int unsigned slot_pos;
   int unsigned cfg_w, cfg_h, act_w, act_h;
   int unsigned prey_thr, pred_thr;
   ppa_rsp_type cell_queue [$];

   function automatic int unsigned sat_dim(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // raster index of neighbor k, or -1 outside the grid
   function automatic int nbr_index(int unsigned x, int unsigned y, int k);
      int nx, ny;
      int dx [8] = '{-1, -1, -1, 0, 0, 1, 1, 1};
      int dy [8] = '{-1, 0, 1, -1, 1, -1, 0, 1};
      nx = int'(x) + dx[k];
      ny = int'(y) + dy[k];
      if (nx < 0 || ny < 0 || nx >= int'(act_w) || ny >= int'(act_h)) return -1;
      return ny * int'(act_w) + nx;
   endfunction

   task automatic update_middle(int unsigned m);
      int unsigned x, y;
      logic [1:0] o, v, nb;
      logic [63:0] pr, dr;
      int idx;
      x = m % act_w;
      y = m / act_w;
      o = old_line[m % LD];
      pr = prey_dly[m % RD];
      dr = pred_dly[m % RD];
      v = o;
      for (int k = 0; k < 8; k++) begin
         idx = nbr_index(x, y, k);
         if (idx >= 0) begin
            nb = old_line[idx % LD];
            if (o == CELL_EMPTY && nb == CELL_PREY && pr[8*k +: 8] < prey_thr)
               v = CELL_PREY;
            if (o == CELL_PREY && nb == CELL_PRED && dr[8*k +: 8] < pred_thr)
               v = CELL_PRED;
         end
      end
      mid_line[m % LD] = v;
   endtask

   function automatic logic [1:0] final_cell(int unsigned n);
      logic [1:0] v;
      int idx;
      v = mid_line[n % LD];
      if (v != CELL_PRED) return v;
      for (int k = 0; k < 8; k++) begin
         idx = nbr_index(n % act_w, n / act_w, k);
         if (idx >= 0 && mid_line[idx % LD] == CELL_PREY) return CELL_PRED;
      end
      return CELL_EMPTY;
   endfunction

   task automatic predict_word(ppa_req_type w);
      int unsigned total, p, n;
      logic [1:0] c;
      ppa_rsp_type r;
      p = slot_pos;
      if (p == 0 && w.mode == 1'b0) begin
         act_w = sat_dim(cfg_w, MAXW);
         act_h = sat_dim(cfg_h, MAXH);
      end
      total = act_w * act_h;
      if (p < total) begin
         // drop a drain word while cells are still expected
         if (w.mode) return;
         c = (w.old_cell == CELL_BAD) ? CELL_EMPTY : w.old_cell;
         old_line[p % LD] = c;
         prey_dly[p % RD] = w.prey_random;
         pred_dly[p % RD] = w.predator_random;
      end
      if (p >= act_w + 1 && p - (act_w + 1) < total) update_middle(p - (act_w + 1));
      if (p >= 2 * act_w + 2) begin
         n = p - (2 * act_w + 2);
         r.new_cell = final_cell(n);
         r.frame_end = (n + 1 >= total);
         cell_queue.push_back(r);
         slot_pos = r.frame_end ? 0 : p + 1;
      end else begin
         slot_pos = p + 1;
      end
   endtask

   always @(posedge clock) begin
      ppa_rsp_type e;
      if (reset) begin
         slot_pos = 0;
         cfg_w = 64; cfg_h = 64; act_w = 64; act_h = 64;
         prey_thr = 218; pred_thr = 218;
         cell_queue.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (cell_queue.size() == 0) begin
               $display("%0t: unexpected result word %p", $time, rsp_data);
               fail_count++;
            end else begin
               e = cell_queue.pop_front();
               if (e.new_cell !== rsp_data.new_cell || e.frame_end !== rsp_data.frame_end) begin
                  $display("%0t: result mismatch expected %p actual %p",
                           $time, e, rsp_data);
                  fail_count++;
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_GRID_WIDTH:  cfg_w = csr_wdata[6:0];
               CSR_GRID_HEIGHT: cfg_h = csr_wdata[6:0];
               CSR_PREY_THR:    prey_thr = csr_wdata;
               CSR_PRED_THR:    pred_thr = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_word(req_data);
      end
      pending_count = cell_queue.size();
   end

endmodule

[tb/tb_top.sv]
// Testbench top for the predator-prey generation block: drives frames of
// cells, drain words and register writes, and gives the verdict.
// Depends on ppa_pkg, ppa_checker and the block itself.
`timescale 1ns / 1ps

module tb_top
   import ppa_pkg::*;
;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   ppa_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   ppa_rsp_type rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = CSR_GRID_WIDTH;
   logic [8:0]  csr_wdata = '0;
   int          fail_count, pending_count;
   int          words_sent;

   always #4 clock = ~clock;

   predator_prey_automaton_step u_dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_wr_en, .csr_index, .csr_wdata
   );

   ppa_checker u_chk (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_wr_en, .csr_index, .csr_wdata,
      .fail_count, .pending_count
   );

   // mostly no gap at all, often a short one, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // receiver side: stall at random, with stall lengths drawn like the input gaps
   always begin
      int g;
      @(negedge clock);
      g = gap_len();
      if (g > 0 && !reset) begin
         rsp_stall <= 1'b1;
         repeat (g) @(negedge clock);
         rsp_stall <= 1'b0;
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [8:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // hold the word until it is taken, then leave valid high for the next
   task automatic send_word(ppa_req_type w);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      words_sent++;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // draw a cell word; directed mode forces extremes of the draw bytes
   function automatic ppa_req_type cell_word(int flavor);
      ppa_req_type w;
      w.mode = 1'b0;
      w.old_cell = $urandom_range(0, 99) < 5 ? CELL_BAD : 2'($urandom_range(0, 2));
      case (flavor)
         1: begin w.prey_random = '0; w.predator_random = '0; end
         2: begin w.prey_random = '1; w.predator_random = '1; end
         default: begin w.prey_random = rand64(); w.predator_random = rand64(); end
      endcase
      return w;
   endfunction

   // send one frame: cells with optional dropped drain words, then the drain
   task automatic run_frame(int w, int h, int flavor, bit noise);
      ppa_req_type d;
      for (int i = 0; i < w * h; i++) begin
         if (noise && $urandom_range(0, 9) == 0) begin
            d = cell_word(0);
            d.mode = 1'b1;
            send_word(d);
         end
         send_word(cell_word(flavor));
      end
      for (int i = 0; i < 2 * w + 2; i++) begin
         // a cell word during the drain acts as a drain word
         d = cell_word(0);
         d.mode = noise ? 1'($urandom_range(0, 1)) : 1'b1;
         send_word(d);
      end
      req_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic set_cfg(int w, int h, int pt, int dt);
      csr_write(CSR_GRID_WIDTH, 9'(w));
      csr_write(CSR_GRID_HEIGHT, 9'(h));
      csr_write(CSR_PREY_THR, 9'(pt));
      csr_write(CSR_PRED_THR, 9'(dt));
   endtask

   initial begin
      int w, h, wr, hr;
      words_sent = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: smallest grids, zero and saturating geometry, threshold extremes
      set_cfg(1, 1, 256, 256);     run_frame(1, 1, 0, 1'b0); wait_idle();
      set_cfg(0, 2, 0, 0);         run_frame(1, 2, 1, 1'b0); wait_idle();
      set_cfg(3, 2, 511, 300);     run_frame(3, 2, 2, 1'b1); wait_idle();
      set_cfg(127, 1, 255, 1);     run_frame(64, 1, 1, 1'b0); wait_idle();
      set_cfg(2, 127, 1, 255);     run_frame(2, 64, 2, 1'b0); wait_idle();

      // random: mostly small grids with random thresholds, a few with zero or saturating width
      while (words_sent < 1300) begin
         if ($urandom_range(0, 19) == 0) begin
            wr = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127); w = (wr == 0) ? 1 : 64;
            hr = $urandom_range(1, 3); h = hr;
         end else begin
            w = $urandom_range(1, 8); h = $urandom_range(1, 8); wr = w; hr = h;
         end
         set_cfg(wr, hr, $urandom_range(0, 99) < 10 ? 256 : $urandom_range(0, 255),
                 $urandom_range(0, 99) < 10 ? 0 : $urandom_range(0, 300));
         run_frame(w, h, 0, $urandom_range(0, 3) == 0);
         wait_idle();
      end
      // full width with the default thresholds
      set_cfg(64, 4, 218, 218);
      run_frame(64, 4, 0, 1'b0);
      wait_idle();
      repeat (20) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("simulation failed");
      $finish;
   end

endmodule
